@@ rtl/core/nss_pkg.sv @@
package nss_pkg;

    localparam int MAX_GRID_DEF = 32;
    localparam int LABEL_W = 5;
    localparam int SIZE_W = 6;
    localparam int THR_W = 9;
    localparam int COORD_W = 5;
    localparam int COUNT_W = 4;

    localparam logic CFG_GRID_SIZE = 1'b0;
    localparam logic CFG_THRESHOLD = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EMIT,
        ST_FLUSH
    } nss_state_t;

    typedef struct packed {
        logic [COORD_W-1:0] cell_row;
        logic [COORD_W-1:0] cell_col;
        logic               is_happy;
        logic [COUNT_W-1:0] same_count;
        logic [COUNT_W-1:0] occupied_count;
        logic               last_of_run;
        logic               end_of_grid;
        logic               all_happy;
    } nss_result_t;

    typedef struct packed {
        logic [LABEL_W-1:0] centre;
        logic [7:0][LABEL_W-1:0] nb;
        logic [7:0]         in_grid;
    } nss_block_t;

endpackage

@@ rtl/core/neighbor_similarity_stencil.sv @@
// Path: an accepted cell goes through ST_READ (line-store read), then ST_EMIT (judge into the
// output register); results trail the input by a row and a column.
// Flow: one cell in flight, accepted in ST_IDLE; a row's last cell gets a second ST_EMIT pass for
// its second result, the grid's last cell adds a flush of the last row, and stalls hold the block.
// Reset: synchronous, active low; positions, window and flags clear, but all-happy sets;
// grid_size MAX_GRID, threshold 128; the line stores keep their contents.
module neighbor_similarity_stencil
    import nss_pkg::*;
#(
    parameter int MAX_GRID = MAX_GRID_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // cell_label[4:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    // cell_row[4:0], cell_col[9:5], same_count[13:10], occupied_count[17:14]
    output logic [23:0] m_tdata,
    output logic        m_tlast,   // last_of_run
    // is_happy[0], end_of_grid[1], all_happy[2]
    output logic [2:0]  m_tuser,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [8:0]  cfg_data
);

    localparam int AW = $clog2(MAX_GRID);
    localparam int PW = $clog2(MAX_GRID + 1);

    nss_state_t state_reg, state_next;
    logic [PW-1:0] size_reg;
    logic [THR_W-1:0] thr_reg;
    logic [PW-1:0] row_reg, col_reg, k_reg;
    logic [2:0][2:0][LABEL_W-1:0] win_reg;
    logic [LABEL_W-1:0] label_reg;
    logic allh_reg;
    logic second_reg;
    logic out_v_reg;
    nss_result_t out_reg;

    logic we;
    logic [AW-1:0] waddr, raddr;
    logic [LABEL_W-1:0] up2, up1;
    logic [LABEL_W-1:0] wd2, wd1;
    logic [PW-1:0] last;
    logic [PW-1:0] fcol;
    logic out_free;

    assign last = size_reg - PW'(1);
    assign fcol = k_reg - PW'(1);
    assign out_free = !out_v_reg || m_tready;
    assign cfg_ready = (state_reg == ST_IDLE);
    assign s_tready = (state_reg == ST_IDLE) && !cfg_valid;

    nss_ram #(.WIDTH(LABEL_W), .DEPTH(MAX_GRID)) u_two (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(wd2), .raddr(raddr), .rdata(up2)
    );
    nss_ram #(.WIDTH(LABEL_W), .DEPTH(MAX_GRID)) u_one (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(wd1), .raddr(raddr), .rdata(up1)
    );

    assign waddr = col_reg[AW-1:0];
    assign wd2 = up1;
    assign wd1 = label_reg;
    assign we = (state_reg == ST_EMIT) && !second_reg && out_free;
    always_comb begin
        raddr = col_reg[AW-1:0];
        if (state_reg == ST_FLUSH) begin
            raddr = AW'(k_reg + PW'(1));
        end else if ((state_reg == ST_EMIT) && second_reg) begin
            raddr = '0;
        end
    end

    // Flush window held in the window register: row 0 = two above, row 1 = one above.
    nss_block_t blk;
    logic happy;
    logic [COUNT_W-1:0] same, occ;
    logic [2:0][LABEL_W-1:0] c0, c1, c2;

    always_comb begin
        blk = '0;
        if (state_reg == ST_FLUSH) begin
            c0 = win_reg[0];
            c1 = win_reg[1];
            c2 = win_reg[2];
            blk.centre = c1[1];
            blk.nb = {c0[0], c0[1], c0[2], c1[0], c1[2], c2[0], c2[1], c2[2]};
            blk.in_grid = {fcol != '0, 1'b1, fcol != last,
                           fcol != '0, fcol != last, 3'b000};
        end else begin
            c0 = {up2, win_reg[0][2], win_reg[0][1]};
            c1 = {up1, win_reg[1][2], win_reg[1][1]};
            c2 = {label_reg, win_reg[2][2], win_reg[2][1]};
            if (second_reg) begin
                c0 = {LABEL_W'(0), win_reg[0][2], win_reg[0][1]};
                c1 = {LABEL_W'(0), win_reg[1][2], win_reg[1][1]};
                c2 = {LABEL_W'(0), win_reg[2][2], win_reg[2][1]};
            end
            blk.centre = c1[1];
            blk.nb = {c0[0], c0[1], c0[2], c1[0], c1[2], c2[0], c2[1], c2[2]};
            blk.in_grid = {(row_reg >= PW'(2)) && (second_reg || col_reg >= PW'(2)),
                           row_reg >= PW'(2),
                           (row_reg >= PW'(2)) && !second_reg,
                           second_reg || col_reg >= PW'(2),
                           !second_reg,
                           second_reg || col_reg >= PW'(2),
                           1'b1,
                           !second_reg};
        end
    end

    nss_judge u_judge (
        .blk(blk), .threshold(thr_reg), .happy(happy), .same(same), .occ(occ)
    );

    logic emit_now, emit_out, out_load, flush_emit, row_end, grid_end, ahappy_now;
    always_comb begin
        row_end = (col_reg == last);
        grid_end = row_end && (row_reg == last);
        emit_now = (state_reg == ST_EMIT) && out_free;
        emit_out = emit_now && (row_reg != '0) && (second_reg || col_reg != '0);
        flush_emit = (state_reg == ST_FLUSH) && out_free && second_reg;
        out_load = emit_out || flush_emit;
        ahappy_now = allh_reg && (happy || blk.centre == '0);
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_tvalid && s_tready) state_next = ST_READ;
            ST_READ: state_next = ST_EMIT;
            ST_EMIT: begin
                if (out_free) begin
                    if (row_end && !second_reg && row_reg != '0) begin
                        state_next = ST_EMIT;
                    end else if (grid_end) begin
                        state_next = ST_FLUSH;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_FLUSH: if (flush_emit && fcol == last) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            size_reg <= PW'(MAX_GRID);
            thr_reg <= THR_W'(128);
            row_reg <= '0;
            col_reg <= '0;
            k_reg <= '0;
            win_reg <= '0;
            allh_reg <= 1'b1;
            second_reg <= 1'b0;
            out_v_reg <= 1'b0;
            label_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                out_v_reg <= 1'b1;
            end else if (m_tready) begin
                out_v_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_GRID_SIZE) begin
                    if (cfg_data[5:0] < 6'd2) size_reg <= PW'(2);
                    else if (32'(cfg_data[5:0]) > MAX_GRID) size_reg <= PW'(MAX_GRID);
                    else size_reg <= PW'(cfg_data[5:0]);
                    row_reg <= '0;
                    col_reg <= '0;
                    win_reg <= '0;
                    allh_reg <= 1'b1;
                end else begin
                    thr_reg <= cfg_data;
                end
            end
            if (s_tvalid && s_tready) label_reg <= s_tdata[LABEL_W-1:0];
            if (emit_now) begin
                if (!second_reg) begin
                    win_reg <= {c2, c1, c0};
                end
                if (emit_out) begin
                    out_reg.cell_row <= COORD_W'(row_reg - PW'(1));
                    out_reg.cell_col <= second_reg ? COORD_W'(last)
                                                   : COORD_W'(col_reg - PW'(1));
                    out_reg.is_happy <= happy;
                    out_reg.same_count <= same;
                    out_reg.occupied_count <= occ;
                    out_reg.last_of_run <= !grid_end && (second_reg || !row_end);
                    out_reg.end_of_grid <= 1'b0;
                    out_reg.all_happy <= 1'b0;
                    allh_reg <= ahappy_now;
                end
                if (row_end && !second_reg && row_reg != '0) begin
                    second_reg <= 1'b1;
                end else begin
                    second_reg <= 1'b0;
                    if (grid_end) begin
                        k_reg <= '0;
                        win_reg <= '0;
                    end else if (row_end) begin
                        col_reg <= '0;
                        row_reg <= row_reg + PW'(1);
                    end else begin
                        col_reg <= col_reg + PW'(1);
                    end
                end
            end
            // Flush: second_reg low = shift in column k_reg, high = judge column k_reg - 1.
            if (state_reg == ST_FLUSH) begin
                if (!second_reg) begin
                    win_reg[0] <= {(k_reg < size_reg) ? up2 : LABEL_W'(0),
                                   win_reg[0][2], win_reg[0][1]};
                    win_reg[1] <= {(k_reg < size_reg) ? up1 : LABEL_W'(0),
                                   win_reg[1][2], win_reg[1][1]};
                    if (k_reg == '0) begin
                        k_reg <= PW'(1);
                    end else begin
                        second_reg <= 1'b1;
                    end
                end else if (out_free) begin
                    out_reg.cell_row <= COORD_W'(last);
                    out_reg.cell_col <= COORD_W'(fcol);
                    out_reg.is_happy <= happy;
                    out_reg.same_count <= same;
                    out_reg.occupied_count <= occ;
                    out_reg.last_of_run <= (fcol == last);
                    out_reg.end_of_grid <= (fcol == last);
                    out_reg.all_happy <= (fcol == last) && ahappy_now;
                    second_reg <= 1'b0;
                    if (fcol == last) begin
                        row_reg <= '0;
                        col_reg <= '0;
                        k_reg <= '0;
                        win_reg <= '0;
                        allh_reg <= 1'b1;
                    end else begin
                        k_reg <= k_reg + PW'(1);
                        allh_reg <= ahappy_now;
                    end
                end
            end
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata = {6'd0, out_reg.occupied_count, out_reg.same_count,
                      out_reg.cell_col, out_reg.cell_row};
    assign m_tlast = out_reg.last_of_run;
    assign m_tuser = {out_reg.all_happy, out_reg.end_of_grid, out_reg.is_happy};

endmodule

@@ rtl/core/nss_ram.sv @@
module nss_ram #(
    parameter int WIDTH = 5,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/core/nss_judge.sv @@
module nss_judge
    import nss_pkg::*;
(
    input  nss_block_t          blk,
    input  logic [THR_W-1:0]    threshold,
    output logic                happy,
    output logic [COUNT_W-1:0]  same,
    output logic [COUNT_W-1:0]  occ
);

    logic [12:0] lhs;
    logic [12:0] rhs;

    always_comb begin
        same = '0;
        occ = '0;
        for (int i = 0; i < 8; i++) begin
            if (blk.in_grid[i] && blk.nb[i] != '0) begin
                occ = occ + COUNT_W'(1);
                if (blk.nb[i] == blk.centre) begin
                    same = same + COUNT_W'(1);
                end
            end
        end
        lhs = {1'b0, same, 8'd0};
        rhs = 13'(threshold) * 13'(occ);
        happy = (occ != '0) && (lhs >= rhs);
    end

endmodule

@@ rtl/core/nss_checker.sv @@
module nss_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tlast,
    input logic [2:0]  m_tuser
);

    property p_hold;
        @(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser);
    endproperty
    a_hold: assert property (p_hold) else $error("Stalled result transaction changed.");

    property p_one_in_flight;
        @(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready;
    endproperty
    a_one_in_flight: assert property (p_one_in_flight)
        else $error("Input accepted while a transaction was in flight.");

    property p_eog_last;
        @(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tlast;
    endproperty
    a_eog_last: assert property (p_eog_last) else $error("End of grid without tlast.");

    property p_allh;
        @(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[2] |-> m_tuser[1];
    endproperty
    a_allh: assert property (p_allh) else $error("All-happy flag outside end of grid.");

    property p_counts;
        @(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[13:10] <= m_tdata[17:14] && m_tdata[17:14] <= 4'd8;
    endproperty
    a_counts: assert property (p_counts) else $error("Neighbor counts inconsistent.");

endmodule

bind neighbor_similarity_stencil nss_checker u_nss_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tlast(m_tlast), .m_tuser(m_tuser)
);

@@ tb/neighbor_similarity_stencil_tb.sv @@
module neighbor_similarity_stencil_tb;
    import nss_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int GRID_CAP = 32;
    localparam int IDLE_LIMIT = 3000;
    localparam int SETTLE_CYCLES = 12;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        m_tlast;
    logic [2:0]  m_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [8:0]  cfg_data;

    neighbor_similarity_stencil dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Shadow state of the stencil.
    logic [LABEL_W-1:0] upper_line [GRID_CAP];
    logic [LABEL_W-1:0] prev_line [GRID_CAP];
    logic [LABEL_W-1:0] window [3][3];
    logic [LABEL_W-1:0] nbhd [3][3];
    int unsigned        cur_row;
    int unsigned        cur_col;
    bit                 grid_content;
    int unsigned        side_len;
    int unsigned        share_thr;

    nss_result_t pending_results[$];
    int          error_count;
    int          idle_cycles;
    bit          rx_stall_en;
    logic        m_tvalid_seen;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic int unsigned clamp_side(int unsigned v);
        if (v < 2) return 2;
        if (v > GRID_CAP) return GRID_CAP;
        return v;
    endfunction

    function automatic void restart_grid();
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                window[i][j] = '0;
        cur_row = 0;
        cur_col = 0;
        grid_content = 1'b1;
    endfunction

    function automatic void apply_config(logic idx, logic [8:0] val);
        if (idx == CFG_GRID_SIZE) begin
            side_len = clamp_side(val[5:0]);
            restart_grid();
        end else begin
            share_thr = val;
        end
    endfunction

    function automatic void judge_cell(bit top, bit bot, bit lft, bit rgt,
                                       int unsigned row, int unsigned col, bit eog);
        int unsigned occ;
        int unsigned same;
        bit          happy;
        nss_result_t res;
        occ = 0;
        same = 0;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                if (i == 1 && j == 1) continue;
                if ((i == 0 && !top) || (i == 2 && !bot)) continue;
                if ((j == 0 && !lft) || (j == 2 && !rgt)) continue;
                if (nbhd[i][j] != 0) begin
                    occ++;
                    if (nbhd[i][j] == nbhd[1][1]) same++;
                end
            end
        end
        happy = occ > 0 && same * 256 >= share_thr * occ;
        if (!happy && nbhd[1][1] != 0) grid_content = 1'b0;
        res.cell_row = row[COORD_W-1:0];
        res.cell_col = col[COORD_W-1:0];
        res.is_happy = happy;
        res.same_count = same[COUNT_W-1:0];
        res.occupied_count = occ[COUNT_W-1:0];
        res.last_of_run = 1'b0;
        res.end_of_grid = eog;
        res.all_happy = eog && grid_content;
        pending_results = {pending_results, res};
    endfunction

    function automatic void predict_cell(logic [LABEL_W-1:0] label);
        int unsigned n;
        int unsigned r;
        int unsigned c;
        int unsigned before_cnt;
        logic [LABEL_W-1:0] up2;
        logic [LABEL_W-1:0] up1;
        n = side_len;
        r = cur_row;
        c = cur_col;
        before_cnt = pending_results.size();
        up2 = upper_line[c];
        up1 = prev_line[c];
        for (int i = 0; i < 3; i++) begin
            window[i][0] = window[i][1];
            window[i][1] = window[i][2];
        end
        window[0][2] = up2;
        window[1][2] = up1;
        window[2][2] = label;
        upper_line[c] = up1;
        prev_line[c] = label;
        if (r >= 1 && c >= 1) begin
            nbhd = window;
            judge_cell(r >= 2, 1'b1, c >= 2, 1'b1, r - 1, c - 1, 1'b0);
        end
        if (r >= 1 && c == n - 1) begin
            for (int i = 0; i < 3; i++) begin
                nbhd[i][0] = window[i][1];
                nbhd[i][1] = window[i][2];
                nbhd[i][2] = '0;
            end
            judge_cell(r >= 2, 1'b1, 1'b1, 1'b0, r - 1, n - 1, 1'b0);
        end
        if (r == n - 1 && c == n - 1) begin
            for (int k = 0; k < n; k++) begin
                for (int j = 0; j < 3; j++) begin
                    if (k + j >= 1 && k + j - 1 < n) begin
                        nbhd[0][j] = upper_line[k + j - 1];
                        nbhd[1][j] = prev_line[k + j - 1];
                    end else begin
                        nbhd[0][j] = '0;
                        nbhd[1][j] = '0;
                    end
                    nbhd[2][j] = '0;
                end
                judge_cell(1'b1, 1'b0, k >= 1, k + 1 < n, n - 1, k, k == n - 1);
            end
            restart_grid();
        end else begin
            c++;
            if (c >= n) begin
                c = 0;
                r++;
                if (r >= n) r = 0;
            end
            cur_row = r;
            cur_col = c;
        end
        if (pending_results.size() > before_cnt) begin
            pending_results[pending_results.size() - 1].last_of_run = 1'b1;
        end
    endfunction

    task automatic send_cell(logic [LABEL_W-1:0] label);
        int gap;
        gap = int'($urandom_range(0, 5));
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata = {3'b000, label};
        do @(posedge aclk); while (!s_tready);
        predict_cell(label);
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(logic idx, logic [8:0] val);
        wait_drained();
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        do @(posedge aclk); while (!cfg_ready);
        apply_config(idx, val);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic send_grid(int unsigned size, int unsigned max_label);
        for (int i = 0; i < size * size; i++) send_cell(5'($urandom_range(0, max_label)));
    endtask

    task automatic test_directed_edges();
        write_reg(CFG_GRID_SIZE, 9'd0);
        write_reg(CFG_THRESHOLD, 9'd0);
        send_cell(5'd31);
        send_cell(5'd31);
        send_cell(5'd31);
        send_cell(5'd0);
        write_reg(CFG_THRESHOLD, 9'd256);
        send_cell(5'd0);
        send_cell(5'd0);
        send_cell(5'd0);
        send_cell(5'd21);
        write_reg(CFG_THRESHOLD, 9'd511);
        send_cell(5'd10);
        send_cell(5'd10);
        send_cell(5'd10);
        send_cell(5'd10);
        write_reg(CFG_GRID_SIZE, 9'd3);
        write_reg(CFG_THRESHOLD, 9'd128);
        send_cell(5'd1);
        send_cell(5'd2);
        send_cell(5'd1);
        send_cell(5'd2);
        send_cell(5'd1);
        send_cell(5'd2);
        send_cell(5'd1);
        send_cell(5'd2);
        send_cell(5'd1);
    endtask

    task automatic test_wide_grid();
        write_reg(CFG_GRID_SIZE, 9'd63);
        write_reg(CFG_THRESHOLD, 9'd85);
        for (int i = 0; i < 40; i++) send_cell(5'($urandom_range(0, 31)));
        write_reg(CFG_GRID_SIZE, 9'd1);
    endtask

    task automatic test_random_grids();
        int sent;
        int unsigned size;
        sent = 0;
        while (sent < 40) begin
            size = ($urandom_range(0, 7) == 0) ? 8 : $urandom_range(2, 5);
            write_reg(CFG_GRID_SIZE, 9'(size));
            case ($urandom_range(0, 3))
                0: write_reg(CFG_THRESHOLD, 9'($urandom_range(0, 511)));
                1: write_reg(CFG_THRESHOLD, 9'd256);
                default: write_reg(CFG_THRESHOLD, 9'($urandom_range(0, 256)));
            endcase
            rx_stall_en = $urandom_range(0, 3) != 0;
            send_grid(size, ($urandom_range(0, 4) == 0) ? 31 : 3);
            sent += int'(size * size);
        end
        rx_stall_en = 1'b1;
    endtask

    task automatic test_midgrid_hold();
        write_reg(CFG_GRID_SIZE, 9'd4);
        write_reg(CFG_THRESHOLD, 9'd128);
        for (int i = 0; i < 7; i++) send_cell(5'($urandom_range(0, 2)));
        write_reg(CFG_THRESHOLD, 9'd200);
        for (int i = 0; i < 9; i++) send_cell(5'($urandom_range(0, 2)));
        wait_drained();
    endtask

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_GRID_SIZE;
        cfg_data = '0;
        error_count = 0;
        rx_stall_en = 1'b1;
        for (int i = 0; i < GRID_CAP; i++) begin
            upper_line[i] = '0;
            prev_line[i] = '0;
        end
        side_len = 32;
        share_thr = 128;
        restart_grid();
        repeat (9) @(negedge aclk);
        aresetn = 1'b1;
        test_directed_edges();
        test_wide_grid();
        test_midgrid_hold();
        test_random_grids();
        wait_drained();
        if (error_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        int stall;
        m_tready = 1'b0;
        stall = 0;
        forever begin
            @(negedge aclk);
            if (m_tready && m_tvalid_seen) stall = rx_stall_en ? int'($urandom_range(0, 5)) : 0;
            if (stall > 0) begin
                m_tready = 1'b0;
                stall--;
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
        if (exp_v != act_v) begin
            $display("%0t %s mismatch: expected %0d actual %0d", $realtime, name, exp_v, act_v);
            error_count++;
        end
    endfunction

    always @(posedge aclk) begin
        nss_result_t exp_r;
        m_tvalid_seen <= aresetn && m_tvalid && m_tready;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t unexpected result: expected none actual row %0d col %0d",
                         $realtime, m_tdata[4:0], m_tdata[9:5]);
                error_count++;
            end else begin
                exp_r = pending_results.pop_front();
                check_field("cell_row", exp_r.cell_row, m_tdata[4:0]);
                check_field("cell_col", exp_r.cell_col, m_tdata[9:5]);
                check_field("same_count", exp_r.same_count, m_tdata[13:10]);
                check_field("occupied_count", exp_r.occupied_count, m_tdata[17:14]);
                check_field("last_of_run", exp_r.last_of_run, m_tlast);
                check_field("is_happy", exp_r.is_happy, m_tuser[0]);
                check_field("end_of_grid", exp_r.end_of_grid, m_tuser[1]);
                check_field("all_happy", exp_r.all_happy, m_tuser[2]);
            end
        end
    end

    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

endmodule
